// File: src/pss_pkg.sv
package pss_pkg;

  // slot index carried on the chain, wide enough for the largest table
  localparam int IDX_MAX_W = 8;

  // best candidate seen so far, handed from cell to cell
  typedef struct packed {
    logic                 found;
    logic [7:0]           prio;
    logic [IDX_MAX_W-1:0] idx;
    logic [15:0]          arrival;
    logic [15:0]          burst;
    logic [15:0]          remaining;
  } pss_cand_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                 load;
    logic                 dec;
    logic [IDX_MAX_W-1:0] idx;
    logic [15:0]          arrival;
    logic [15:0]          burst;
    logic [7:0]           prio;
  } pss_cmd_t;

  // per-cell status seen by the controller
  typedef struct packed {
    logic valid;
    logic done;
  } pss_stat_t;

endpackage

// File: src/pss_cell.sv
module pss_cell
  import pss_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pss_cmd_t  cmd,
  input  logic [31:0] now,
  input  pss_cand_t cand_in,
  output pss_cand_t cand_out,
  output pss_stat_t stat
);

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

  logic        valid_r;
  logic [15:0] arrival_r;
  logic [15:0] burst_r;
  logic [15:0] remaining_r;
  logic [7:0]  prio_r;
  pss_cand_t   cand_r;
  pss_cand_t   cand_nxt;
  logic        hit;
  logic        eligible;

  assign hit = (cmd.idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.load && hit) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && hit) begin
      arrival_r   <= cmd.arrival;
      burst_r     <= cmd.burst;
      prio_r      <= cmd.prio;
      remaining_r <= cmd.burst;
    end else if (cmd.dec && hit) begin
      remaining_r <= remaining_r - 16'd1;
    end
  end

  assign eligible = valid_r && (remaining_r != 16'd0) && ({16'd0, arrival_r} <= now);

  // strict compare keeps the earlier slot on a tie
  always_comb begin
    cand_nxt = cand_in;
    if (eligible && (!cand_in.found || (prio_r < cand_in.prio))) begin
      cand_nxt.found     = 1'b1;
      cand_nxt.prio      = prio_r;
      cand_nxt.idx       = MY_IDX;
      cand_nxt.arrival   = arrival_r;
      cand_nxt.burst     = burst_r;
      cand_nxt.remaining = remaining_r;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  assign cand_out = cand_r;
  assign stat     = '{valid: valid_r, done: (remaining_r == 16'd0)};

endmodule

// File: src/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler over a row of task slot cells.
// Input: raise start with the in_ fields; the item is taken at a rising edge
// with start high and busy low. A load (in_req_type 0) writes one slot in
// that cycle and gives no result; busy stays low, so loads can follow
// back to back. A load to a slot beyond the table is dropped.
// A tick (in_req_type 1) raises busy while the best candidate ripples
// through the cell chain one slot per cycle; then the serve state serves
// the winner and registers its times, and the out state forms the report.
// The result shows on the out_ ports for one cycle with out_valid high,
// in the first cycle with busy low again, so the next item can be taken
// in that cycle. The chain length sets how long busy stays high.
// The receiver cannot stall: every result is taken in its strobe cycle.
// Reset (rst_n low, synchronous) clears all slot valid bits, time and the
// slot counters; slot contents are only read after a load writes them.
module preemptive_priority_scheduler_top
  import pss_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_arrival,
  input  logic [15:0] in_burst,
  input  logic [7:0]  in_prio,
  output logic        out_valid,
  output logic [31:0] out_tick_time,
  output logic        out_idle,
  output logic [3:0]  out_run_slot,
  output logic        out_finished,
  output logic [31:0] out_completion,
  output logic [31:0] out_turnaround,
  output logic [31:0] out_waiting,
  output logic        out_all_done
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SERVE = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      now_r;
  logic [CNT_W-1:0] valid_cnt_r, done_cnt_r;

  pss_cand_t link [NUM_SLOTS+1];
  pss_stat_t stat [NUM_SLOTS];
  pss_cmd_t  cmd;
  pss_cand_t win;

  logic             accept;
  logic             ld_go;
  logic             tick_go;
  logic [IDX_W-1:0] ld_idx;
  logic             ld_was_valid;
  logic             ld_was_done;
  logic             win_fin;
  logic [31:0]      compl;

  // serve stage
  logic        s_found_r, s_fin_r;
  logic [3:0]  s_slot_r;
  logic [31:0] s_tick_r, s_compl_r, s_tat_r;
  logic [15:0] s_burst_r;

  logic        out_valid_r;
  logic [31:0] out_tick_time_r, out_completion_r, out_turnaround_r, out_waiting_r;
  logic        out_idle_r, out_finished_r, out_all_done_r;
  logic [3:0]  out_run_slot_r;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign tick_go = accept && in_req_type;
  assign ld_go   = accept && !in_req_type && (32'(in_slot) < NUM_SLOTS);
  assign ld_idx  = IDX_W'(in_slot);
  assign win     = link[NUM_SLOTS];
  assign win_fin = win.found && (win.remaining == 16'd1);
  assign compl   = (now_r == 32'hFFFF_FFFF) ? now_r : now_r + 32'd1;

  assign ld_was_valid = stat[ld_idx].valid;
  assign ld_was_done  = stat[ld_idx].done;

  always_comb begin
    cmd.load    = ld_go;
    cmd.dec     = (state_r == ST_SERVE) && win.found;
    cmd.idx     = ld_go ? IDX_MAX_W'(in_slot) : win.idx;
    cmd.arrival = in_arrival;
    cmd.burst   = in_burst;
    cmd.prio    = in_prio;
  end

  assign link[0] = '0;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    pss_cell #(
      .IDX(g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .now      (now_r),
      .cand_in  (link[g]),
      .cand_out (link[g+1]),
      .stat     (stat[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (tick_go) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(NUM_SLOTS - 1)) state_nxt = ST_SERVE;
      end
      ST_SERVE: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      now_r       <= '0;
      valid_cnt_r <= '0;
      done_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == ST_OUT);
      if (ld_go) begin
        if (!ld_was_valid) valid_cnt_r <= valid_cnt_r + CNT_W'(1);
        // reload of a finished slot takes it out of the done count
        done_cnt_r <= done_cnt_r
                      - CNT_W'(ld_was_valid && ld_was_done)
                      + CNT_W'(in_burst == 16'd0);
      end else if (state_r == ST_SERVE) begin
        if (win_fin) done_cnt_r <= done_cnt_r + CNT_W'(1);
        if (now_r != 32'hFFFF_FFFF) now_r <= now_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SERVE) begin
      s_found_r <= win.found;
      s_fin_r   <= win_fin;
      s_slot_r  <= win.found ? win.idx[3:0] : 4'd0;
      s_tick_r  <= now_r;
      s_compl_r <= win_fin ? compl : 32'd0;
      s_tat_r   <= win_fin ? compl - {16'd0, win.arrival} : 32'd0;
      s_burst_r <= win_fin ? win.burst : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT) begin
      out_tick_time_r  <= s_tick_r;
      out_idle_r       <= !s_found_r;
      out_run_slot_r   <= s_slot_r;
      out_finished_r   <= s_fin_r;
      out_completion_r <= s_compl_r;
      out_turnaround_r <= s_tat_r;
      // clamp, only reachable once time has saturated
      out_waiting_r    <= (s_tat_r >= {16'd0, s_burst_r}) ?
                          s_tat_r - {16'd0, s_burst_r} : 32'd0;
      out_all_done_r   <= (done_cnt_r == valid_cnt_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tick_time  = out_tick_time_r;
  assign out_idle       = out_idle_r;
  assign out_run_slot   = out_run_slot_r;
  assign out_finished   = out_finished_r;
  assign out_completion = out_completion_r;
  assign out_turnaround = out_turnaround_r;
  assign out_waiting    = out_waiting_r;
  assign out_all_done   = out_all_done_r;

endmodule

// File: tb/preemptive_priority_scheduler_top_tb.sv
module preemptive_priority_scheduler_top_tb;

  localparam int NUM_SLOTS = 16;
  localparam bit REQ_LOAD = 1'b0;
  localparam bit REQ_TICK = 1'b1;
  localparam logic [31:0] TIME_SAT = 32'hFFFF_FFFF;
  localparam int RAND_ITEMS = 850;

  typedef struct {
    logic [31:0] tick_time;
    logic        idle;
    logic [3:0]  run_slot;
    logic        finished;
    logic [31:0] completion;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        all_done;
  } tick_report_t;

  class sched_checker;
    bit          slot_live [NUM_SLOTS];
    bit [15:0]   slot_arr  [NUM_SLOTS];
    bit [15:0]   slot_bur  [NUM_SLOTS];
    bit [15:0]   slot_left [NUM_SLOTS];
    bit [7:0]    slot_pri  [NUM_SLOTS];
    bit [31:0]   now_t;
    int unsigned n_done;
    int unsigned n_valid;
    tick_report_t expected_ticks [$];
    int unsigned errors;
    int unsigned n_loads;
    int unsigned n_ticks;
    int unsigned n_idle;
    int unsigned n_finished;

    function new();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      now_t = '0;
      n_done = 0;
      n_valid = 0;
      errors = 0;
      n_loads = 0;
      n_ticks = 0;
      n_idle = 0;
      n_finished = 0;
    endfunction

    // an accepted item: a load updates the table, a tick predicts its report
    function void note_input(bit req, bit [3:0] idx, bit [15:0] arr, bit [15:0] bur,
                             bit [7:0] pri);
      tick_report_t r;
      int best;
      bit found;
      if (req == REQ_LOAD) begin
        n_loads++;
        if (idx < NUM_SLOTS) begin
          if (slot_live[idx]) begin
            // a finished slot that is reloaded counts as unfinished again
            if (slot_left[idx] == 0 && n_done > 0) n_done--;
          end else begin
            slot_live[idx] = 1'b1;
            n_valid++;
          end
          slot_arr[idx] = arr;
          slot_pri[idx] = pri;
          slot_bur[idx] = bur;
          slot_left[idx] = bur;
          if (bur == 0) n_done++;
        end
        return;
      end
      found = 1'b0;
      best = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_live[i] && slot_left[i] != 0 && {16'd0, slot_arr[i]} <= now_t) begin
          if (!found || slot_pri[i] < slot_pri[best]) begin
            best = i;
            found = 1'b1;
          end
        end
      end
      r.tick_time = now_t;
      r.idle = !found;
      r.run_slot = found ? best[3:0] : 4'd0;
      r.finished = 1'b0;
      r.completion = '0;
      r.turnaround = '0;
      r.waiting = '0;
      if (found) begin
        slot_left[best] = slot_left[best] - 16'd1;
        if (slot_left[best] == 0) begin
          r.finished = 1'b1;
          n_done++;
          r.completion = (now_t == TIME_SAT) ? TIME_SAT : now_t + 32'd1;
          r.turnaround = r.completion - {16'd0, slot_arr[best]};
          // only saturated time can push waiting below zero
          r.waiting = (r.turnaround >= {16'd0, slot_bur[best]}) ?
                      r.turnaround - {16'd0, slot_bur[best]} : 32'd0;
          n_finished++;
        end
      end else begin
        n_idle++;
      end
      r.all_done = (n_done == n_valid);
      if (now_t != TIME_SAT) now_t++;
      expected_ticks.push_back(r);
      n_ticks++;
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(tick_report_t got);
      tick_report_t want;
      bit ok;
      if (expected_ticks.size() == 0) begin
        $display("%0t: unexpected result, expected none actual tick_time %0h", $time,
                 got.tick_time);
        errors++;
        return;
      end
      want = expected_ticks.pop_front();
      ok = 1'b1;
      ok &= field_ok("tick_time", want.tick_time, got.tick_time);
      ok &= field_ok("idle", {31'd0, want.idle}, {31'd0, got.idle});
      ok &= field_ok("run_slot", {28'd0, want.run_slot}, {28'd0, got.run_slot});
      ok &= field_ok("finished", {31'd0, want.finished}, {31'd0, got.finished});
      ok &= field_ok("completion", want.completion, got.completion);
      ok &= field_ok("turnaround", want.turnaround, got.turnaround);
      ok &= field_ok("waiting", want.waiting, got.waiting);
      ok &= field_ok("all_done", {31'd0, want.all_done}, {31'd0, got.all_done});
      if (!ok) errors++;
    endfunction

    function void finish_check();
      if (expected_ticks.size() != 0) begin
        $display("%0t: %0d tick reports never arrived, expected tick_time %0h actual none",
                 $time, expected_ticks.size(), expected_ticks[0].tick_time);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [3:0]  in_slot;
  logic [15:0] in_arrival;
  logic [15:0] in_burst;
  logic [7:0]  in_prio;
  logic        out_valid;
  logic [31:0] out_tick_time;
  logic        out_idle;
  logic [3:0]  out_run_slot;
  logic        out_finished;
  logic [31:0] out_completion;
  logic [31:0] out_turnaround;
  logic [31:0] out_waiting;
  logic        out_all_done;

  sched_checker sb;

  preemptive_priority_scheduler_top #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_slot(in_slot),
    .in_arrival(in_arrival),
    .in_burst(in_burst),
    .in_prio(in_prio),
    .out_valid(out_valid),
    .out_tick_time(out_tick_time),
    .out_idle(out_idle),
    .out_run_slot(out_run_slot),
    .out_finished(out_finished),
    .out_completion(out_completion),
    .out_turnaround(out_turnaround),
    .out_waiting(out_waiting),
    .out_all_done(out_all_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    tick_report_t seen;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      seen.tick_time = out_tick_time;
      seen.idle = out_idle;
      seen.run_slot = out_run_slot;
      seen.finished = out_finished;
      seen.completion = out_completion;
      seen.turnaround = out_turnaround;
      seen.waiting = out_waiting;
      seen.all_done = out_all_done;
      sb.check_result(seen);
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(input bit req, input bit [3:0] idx, input bit [15:0] arr,
                           input bit [15:0] bur, input bit [7:0] pri);
    @(negedge clk);
    start <= 1'b1;
    in_req_type <= req;
    in_slot <= idx;
    in_arrival <= arr;
    in_burst <= bur;
    in_prio <= pri;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_input(req, idx, arr, bur, pri);
  endtask

  // the other fields of a tick are ignored, so they carry noise
  task automatic send_tick();
    send_item(REQ_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_reports();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_ticks.size() != 0) @(negedge clk);
  endtask

  // arrivals mostly near the current time so that tasks actually get served
  task automatic random_item();
    bit        req;
    bit [3:0]  idx;
    bit [15:0] arr;
    bit [15:0] bur;
    bit [7:0]  pri;
    int        base;
    int        pick;
    req = ($urandom_range(0, 99) < 40) ? REQ_LOAD : REQ_TICK;
    idx = 4'($urandom_range(0, NUM_SLOTS - 1));
    pri = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 6) == 0) begin
      arr = 16'($urandom);
    end else begin
      base = int'(sb.now_t[15:0]) + $urandom_range(0, 12);
      if (base > 10) base = base - $urandom_range(0, 10);
      arr = 16'(base);
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) bur = 16'd0;
    else if (pick == 1) bur = 16'($urandom);
    else if (pick < 4) bur = 16'($urandom_range(7, 40));
    else bur = 16'($urandom_range(1, 6));
    send_item(req, idx, arr, bur, pri);
  endtask

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("preemptive_priority_scheduler_top_tb: FAIL");
    $finish;
  end

  initial begin
    int left;
    int run_len;
    bit drained;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_LOAD;
    in_slot = '0;
    in_arrival = '0;
    in_burst = '0;
    in_prio = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table reports idle with all work done
    send_tick();
    // zero burst slot is done at once and never served
    send_item(REQ_LOAD, 4'd0, 16'd0, 16'd0, 8'd0);
    send_tick();
    // field extremes, never arrives in this run
    send_item(REQ_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);
    // equal priority goes to the lower slot, a later arrival of higher priority overtakes a waiting slot
    send_item(REQ_LOAD, 4'd3, 16'd0, 16'd2, 8'd5);
    send_item(REQ_LOAD, 4'd7, 16'd0, 16'd1, 8'd5);
    send_item(REQ_LOAD, 4'd9, 16'd4, 16'd1, 8'd0);
    repeat (5) send_tick();
    // reload of a finished slot and of the pending extreme slot
    send_item(REQ_LOAD, 4'd3, 16'd0, 16'd1, 8'd200);
    send_item(REQ_LOAD, 4'd15, 16'd0, 16'd1, 8'hFF);
    repeat (3) send_tick();
    drain_reports();

    left = RAND_ITEMS;
    drained = 1'b0;
    while (left > 0) begin
      run_len = $urandom_range(1, 30);
      while (run_len > 0 && left > 0) begin
        random_item();
        run_len--;
        left--;
      end
      if (!drained && left < RAND_ITEMS / 2) begin
        drain_reports();
        drained = 1'b1;
      end
      hold_off(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6));
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_ticks.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 8) @(posedge clk);
    sb.finish_check();
    $display("covered %0d loads and %0d ticks with random gaps and one full drain",
             sb.n_loads, sb.n_ticks);
    $display("%0d tasks ran to completion, %0d ticks found nothing ready",
             sb.n_finished, sb.n_idle);
    if (sb.errors == 0) begin
      $display("preemptive_priority_scheduler_top_tb: PASS");
    end else begin
      $display("preemptive_priority_scheduler_top_tb: FAIL");
    end
    $finish;
  end

endmodule
